[hdl/assert_macros.svh]
// Assertion macros used by the tokenizer's parse state machine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/htok_pkg.sv]
// Types, constants and helper functions of the HTTP message byte tokenizer.
package htok_pkg;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_SP    = 8'h20;

   localparam logic [3:0] K_DROP   = 4'd0;
   localparam logic [3:0] K_METHOD = 4'd1;
   localparam logic [3:0] K_URI    = 4'd2;
   localparam logic [3:0] K_PNAME  = 4'd3;
   localparam logic [3:0] K_PVER   = 4'd4;
   localparam logic [3:0] K_CODE   = 4'd5;
   localparam logic [3:0] K_REASON = 4'd6;
   localparam logic [3:0] K_KEY    = 4'd7;
   localparam logic [3:0] K_VALUE  = 4'd8;
   localparam logic [3:0] K_BODY   = 4'd9;

   localparam int unsigned RSP_DATA_WIDTH = 16;

   typedef enum logic [4:0] {
      PH_START,
      PH_RQ_METHOD, PH_RQ_SP_URI, PH_RQ_URI, PH_RQ_SP_PROTO,
      PH_RQ_PROTO, PH_RQ_VER, PH_RQ_LF,
      PH_RS_PROTO, PH_RS_VER, PH_RS_SP_CODE, PH_RS_CODE,
      PH_RS_SP_REASON, PH_RS_REASON, PH_RS_LF,
      PH_H_START, PH_H_KEY, PH_H_COLON, PH_H_SP_VAL, PH_H_VALUE,
      PH_H_CR, PH_H_DONE, PH_BODY
   } phase_type;

   typedef struct packed {
      logic       body_seen;
      logic       body_start;
      logic       header_commit;
      logic [7:0] field_char;
      logic [3:0] field_kind;
   } result_type;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

[hdl/http_message_byte_tokenizer.sv]
// Top level of the HTTP message byte tokenizer with its request and result registers.
//
// Each request on the req_ channel carries one byte of an HTTP message buffer
// in req_tdata, and req_tlast marks the final byte of the buffer. For every
// request one result leaves on the rsp_ channel, in order, naming the field
// the byte belongs to together with the byte itself and three status flags.
// The csr_ port writes the mode bit: 0 selects the request-line grammar and
// 1 the status-line grammar; it is sampled when a buffer's first line begins.
// A request is registered on acceptance, tagged by the parse state machine in
// the next cycle and loaded into the result register once that can advance,
// so rsp_tvalid rises once the result register is loaded. One request is
// taken every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its result and the
// request register can still take one more request before req_tready falls.
// Reset empties both registers, clears the mode bit and returns the parser to
// the start of a first line. After the last byte of a buffer the parser
// restarts on its own.
module http_message_byte_tokenizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // data_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // field_kind, field_char, header_commit, body_start, body_seen, zero pad
   output logic [htok_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import htok_pkg::*;

   logic       mode_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - $bits(result_type)){1'b0}}, out_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_ff <= result;
      end
   end

   htok_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance & in_valid_ff),
      .data_byte      (in_byte_ff),
      .last_in_buffer (in_last_ff),
      .message_mode   (mode_ff),
      .result         (result)
   );

endmodule

[hdl/htok_parser.sv]
// Parse state machine that tags one byte per step with its HTTP field.
`include "assert_macros.svh"

module htok_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_in_buffer,
   input  logic                 message_mode,
   output htok_pkg::result_type result
);
   import htok_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic       body_ff;
   logic       body_in;
   logic [3:0] kind;
   logic [7:0] ch;
   logic       commit;
   logic       bstart;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         body_ff  <= 1'b0;
      end else if (step) begin
         if (last_in_buffer) begin
            phase_ff <= PH_START;
            body_ff  <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            body_ff  <= body_in;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      body_in  = body_ff;
      kind     = K_DROP;
      ch       = data_byte;
      commit   = 1'b0;
      bstart   = 1'b0;
      case (phase_ff)
         PH_RQ_METHOD: begin
            if (data_byte == CH_SP) phase_in = PH_RQ_SP_URI; else kind = K_METHOD;
         end
         PH_RQ_SP_URI: begin
            if (data_byte == CH_SLASH) begin
               phase_in = PH_RQ_URI;
               kind     = K_URI;
            end
         end
         PH_RQ_URI: begin
            if (data_byte == CH_SP) phase_in = PH_RQ_SP_PROTO; else kind = K_URI;
         end
         PH_RQ_SP_PROTO: begin
            kind = K_PNAME;
            if (data_byte == CH_H) phase_in = PH_RQ_PROTO;
         end
         PH_RQ_PROTO: begin
            if (data_byte == CH_SLASH) phase_in = PH_RQ_VER; else kind = K_PNAME;
         end
         PH_RQ_VER: begin
            if (data_byte == CH_CR) phase_in = PH_RQ_LF; else kind = K_PVER;
         end
         PH_RQ_LF, PH_RS_LF: begin
            if (data_byte == CH_LF) phase_in = PH_H_START;
         end
         PH_RS_PROTO: begin
            if (data_byte == CH_SLASH) phase_in = PH_RS_VER; else kind = K_PNAME;
         end
         PH_RS_VER: begin
            if (data_byte == CH_SP) phase_in = PH_RS_SP_CODE; else kind = K_PVER;
         end
         PH_RS_SP_CODE: begin
            if (data_byte != CH_SP) begin
               phase_in = PH_RS_CODE;
               kind     = K_CODE;
            end
         end
         PH_RS_CODE: begin
            if (data_byte == CH_SP) phase_in = PH_RS_SP_REASON; else kind = K_CODE;
         end
         PH_RS_SP_REASON: begin
            if (data_byte != CH_SP) begin
               phase_in = PH_RS_REASON;
               kind     = K_REASON;
            end
         end
         PH_RS_REASON: begin
            if (data_byte == CH_CR) phase_in = PH_RS_LF; else kind = K_REASON;
         end
         PH_H_START: begin
            if (data_byte == CH_CR) begin
               phase_in = PH_H_DONE;
            end else begin
               phase_in = PH_H_KEY;
               kind     = K_KEY;
               ch       = lower_ascii(data_byte);
            end
         end
         PH_H_KEY: begin
            if (data_byte == CH_COLON) begin
               phase_in = PH_H_COLON;
            end else begin
               kind = K_KEY;
               ch   = lower_ascii(data_byte);
            end
         end
         PH_H_COLON: begin
            if (data_byte == CH_SP) phase_in = PH_H_SP_VAL;
         end
         PH_H_SP_VAL: begin
            if (data_byte != CH_SP) begin
               phase_in = PH_H_VALUE;
               kind     = K_VALUE;
            end
         end
         PH_H_VALUE: begin
            if (data_byte == CH_CR) phase_in = PH_H_CR; else kind = K_VALUE;
         end
         PH_H_CR: begin
            if (data_byte == CH_LF) begin
               phase_in = PH_H_START;
               commit   = 1'b1;
            end
         end
         PH_H_DONE: begin
            if (data_byte == CH_LF) phase_in = PH_BODY;
         end
         PH_BODY: begin
            kind    = K_BODY;
            bstart  = ~body_ff;
            body_in = 1'b1;
         end
         default: begin
            if (data_byte != CH_CR && data_byte != CH_LF) begin
               if (message_mode) begin
                  phase_in = PH_RS_PROTO;
                  kind     = K_PNAME;
               end else begin
                  phase_in = PH_RQ_METHOD;
                  kind     = K_METHOD;
               end
            end else begin
               phase_in = PH_START;
            end
         end
      endcase
      if (kind == K_DROP) begin
         ch = 8'h00;
      end
      result.field_kind    = kind;
      result.field_char    = ch;
      result.header_commit = commit;
      result.body_start    = bstart;
      result.body_seen     = body_in;
   end

   `ASSERT_NEXT_CYCLE(a_last_restarts, clock, reset, step && last_in_buffer,
                      phase_ff == PH_START && !body_ff)
   `ASSERT_SAME_CYCLE(a_body_rise, clock, reset, $rose(body_ff),
                      $past(step) && $past(phase_ff) == PH_BODY)
   `ASSERT_NEXT_CYCLE(a_commit_next, clock, reset, step && result.header_commit,
                      phase_ff == PH_H_START || $past(last_in_buffer))
   `ASSERT_SAME_CYCLE(a_start_kind, clock, reset, step && result.body_start,
                      result.field_kind == K_BODY && !body_ff)

endmodule
